@@ rtl/mkrs_pkg.sv @@
package mkrs_pkg;

  localparam int BATCH_ROWS_DEFAULT = 64;
  localparam int MAX_KEYS = 4;
  localparam int KEY_FIELDS = 4;
  localparam int KEY_W = 32;
  localparam int REF_W = 16;
  localparam int KEY_COUNT_W = 3;
  localparam int DESC_MASK_W = 4;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_KEY_COUNT = 1'b0;
  localparam logic REG_DESC_MASK = 1'b1;

  typedef struct packed {
    logic [KEY_FIELDS-1:0][KEY_W-1:0] keys;
    logic [REF_W-1:0]                 row_ref;
  } row_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic                   phase;
    logic [KEY_COUNT_W-1:0] nkeys;
    logic [DESC_MASK_W-1:0] desc_mask;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_DRAIN
  } sorter_state_t;

  // True when row x must be placed strictly after row y.
  function automatic logic row_after(row_t x, row_t y, logic [KEY_COUNT_W-1:0] nkeys,
                                     logic [DESC_MASK_W-1:0] desc_mask);
    logic result;
    logic decided;
    result  = 1'b0;
    decided = 1'b0;
    for (int k = 0; k < KEY_FIELDS; k++) begin
      if (!decided && (nkeys > KEY_COUNT_W'(k)) && (x.keys[k] != y.keys[k])) begin
        result  = (x.keys[k] > y.keys[k]) ^ desc_mask[k];
        decided = 1'b1;
      end
    end
    return result;
  endfunction

endpackage

@@ rtl/multikey_batch_row_sorter.sv @@
// Loading takes one row per cycle; a row enters the bottom cell of the chain.
// When a batch of n rows closes, the chain runs BATCH_ROWS phases of odd-even
// transposition, then lifts the rows to the top cell and emits one row per cycle
// while the output register is free to take it.
// Synchronous reset empties the chain and sets key_count to 1 and descending_mask to 0.
module multikey_batch_row_sorter
  import mkrs_pkg::*;
#(
  parameter int BATCH_ROWS = BATCH_ROWS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KEY_W-1:0]      key_a,
  input  logic [KEY_W-1:0]      key_b,
  input  logic [KEY_W-1:0]      key_c,
  input  logic [KEY_W-1:0]      key_d,
  input  logic [REF_W-1:0]      row_ref,
  input  logic                  last_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KEY_W-1:0]      out_key_a,
  output logic [KEY_W-1:0]      out_key_b,
  output logic [KEY_W-1:0]      out_key_c,
  output logic [KEY_W-1:0]      out_key_d,
  output logic [REF_W-1:0]      out_row_ref,
  output logic                  run_end,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CW = $clog2(BATCH_ROWS + 1);

  // The batch lives in a chain of cells. Cell 0 is the bottom, where rows enter
  // during loading; the top cell feeds the output register during the drain.
  // Higher cells hold rows that come out earlier, so arrival order, oldest at
  // the top, is already the stable tie order before sorting begins.

  sorter_state_t          state;
  sorter_state_t          state_next;
  logic [CW-1:0]          fill;
  logic [CW-1:0]          fill_next;
  logic [CW-1:0]          phase_cnt;
  logic [CW-1:0]          phase_cnt_next;
  logic [CW-1:0]          remaining;
  logic [CW-1:0]          remaining_next;
  logic [KEY_COUNT_W-1:0] key_count;
  logic [DESC_MASK_W-1:0] descending_mask;
  logic [KEY_COUNT_W-1:0] nkeys_eff;

  row_t                   in_row;
  row_t                   out_row;
  cell_ctrl_t             ctrl;
  logic                   in_fire;
  logic                   top_valid;
  logic                   out_free;
  logic                   emit;
  logic                   cfg_write;

  row_t                   cell_row [BATCH_ROWS];
  row_t                   lo_row   [BATCH_ROWS];
  row_t                   up_row   [BATCH_ROWS];
  logic [BATCH_ROWS-1:0]  cell_valid;
  logic [BATCH_ROWS-1:0]  cell_swap;
  logic [BATCH_ROWS-1:0]  lo_valid;
  logic [BATCH_ROWS-1:0]  lo_swap;
  logic [BATCH_ROWS-1:0]  up_valid;

  // Configuration port. Register writes take effect at once; the sort pass
  // reads them only after the batch has closed.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count       <= KEY_COUNT_W'(1);
      descending_mask <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_KEY_COUNT: key_count <= pwdata[KEY_COUNT_W-1:0];
        REG_DESC_MASK: descending_mask <= pwdata[DESC_MASK_W-1:0];
        default: key_count <= key_count;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_KEY_COUNT: prdata = APB_DATA_W'(key_count);
      REG_DESC_MASK: prdata = APB_DATA_W'(descending_mask);
      default: prdata = '0;
    endcase
  end

  // A key count of zero behaves as one, and one above the supported number of
  // keys is held at that number.
  always_comb begin
    if (key_count == '0) begin
      nkeys_eff = KEY_COUNT_W'(1);
    end else if (key_count > KEY_COUNT_W'(MAX_KEYS)) begin
      nkeys_eff = KEY_COUNT_W'(MAX_KEYS);
    end else begin
      nkeys_eff = key_count;
    end
  end

  assign in_row.keys[0] = key_a;
  assign in_row.keys[1] = key_b;
  assign in_row.keys[2] = key_c;
  assign in_row.keys[3] = key_d;
  assign in_row.row_ref = row_ref;

  assign top_valid = cell_valid[BATCH_ROWS-1];
  assign out_row   = cell_row[BATCH_ROWS-1];
  assign out_free  = !out_valid || out_ready;

  // Sequencer. Loading accepts a beat every cycle; the sort pass runs a fixed
  // BATCH_ROWS phases, alternating even and odd pairs; the drain shifts the
  // chain upwards whenever the top cell is empty or the output register can
  // take its row.
  always_comb begin
    state_next     = state;
    fill_next      = fill;
    phase_cnt_next = phase_cnt;
    remaining_next = remaining;
    in_ready       = 1'b0;
    in_fire        = 1'b0;
    emit           = 1'b0;
    ctrl.op        = OP_HOLD;
    ctrl.phase     = phase_cnt[0];
    ctrl.nkeys     = nkeys_eff;
    ctrl.desc_mask = descending_mask;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        in_fire  = in_valid;
        if (in_fire) begin
          ctrl.op = OP_SHIFT;
          if (last_row || (fill == CW'(BATCH_ROWS - 1))) begin
            state_next     = ST_SORT;
            fill_next      = '0;
            phase_cnt_next = '0;
            remaining_next = fill + CW'(1);
          end else begin
            fill_next = fill + CW'(1);
          end
        end
      end
      ST_SORT: begin
        ctrl.op        = OP_SORT;
        phase_cnt_next = phase_cnt + CW'(1);
        if (phase_cnt == CW'(BATCH_ROWS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        emit = top_valid && out_free;
        if (!top_valid || out_free) begin
          ctrl.op = OP_SHIFT;
        end
        if (emit) begin
          remaining_next = remaining - CW'(1);
          if (remaining == CW'(1)) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      fill      <= '0;
      phase_cnt <= '0;
      remaining <= '0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      phase_cnt <= phase_cnt_next;
      remaining <= remaining_next;
    end
  end

  // Output register: it parts the chain from the consumer, so the next batch
  // can start loading while the final beat of this one still waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_key_a   <= out_row.keys[0];
      out_key_b   <= out_row.keys[1];
      out_key_c   <= out_row.keys[2];
      out_key_d   <= out_row.keys[3];
      out_row_ref <= out_row.row_ref;
      run_end     <= (remaining == CW'(1));
    end
  end

  // The chain. The bottom cell is fed from the input port during loading and
  // with empty slots during the drain; the top cell has no upper neighbour.
  for (genvar i = 0; i < BATCH_ROWS; i++) begin : g_chain
    if (i == 0) begin : g_bottom
      assign lo_row[i]   = in_row;
      assign lo_valid[i] = in_ready;
      assign lo_swap[i]  = 1'b0;
    end else begin : g_inner_lo
      assign lo_row[i]   = cell_row[i-1];
      assign lo_valid[i] = cell_valid[i-1];
      assign lo_swap[i]  = cell_swap[i-1];
    end
    if (i == BATCH_ROWS - 1) begin : g_top
      assign up_row[i]   = cell_row[i];
      assign up_valid[i] = 1'b0;
    end else begin : g_inner_up
      assign up_row[i]   = cell_row[i+1];
      assign up_valid[i] = cell_valid[i+1];
    end

    mkrs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .odd_pos  (1'(i % 2)),
      .lo_row   (lo_row[i]),
      .lo_valid (lo_valid[i]),
      .lo_swap  (lo_swap[i]),
      .up_row   (up_row[i]),
      .up_valid (up_valid[i]),
      .row      (cell_row[i]),
      .valid    (cell_valid[i]),
      .swap     (cell_swap[i])
    );
  end

  // While loading, the occupied cells are exactly as many as the rows taken.
  a_load_occupancy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (CW'($countones(cell_valid)) == fill))
    else $error("chain occupancy differs from the fill count while loading");

  // Sorting only exchanges rows, so the number of occupied cells stays put.
  a_sort_keeps_rows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORT) |-> (CW'($countones(cell_valid)) == remaining))
    else $error("sort pass lost or duplicated a row");

  // The beat that closes a batch hands control back to loading.
  a_run_end_reloads: assert property (@(posedge clk) disable iff (rst)
    (emit && (remaining == CW'(1))) |=> (state == ST_LOAD) && run_end && out_valid)
    else $error("final beat of a batch did not end the drain");

  // Two active pairs never overlap, so no cell exchanges with both neighbours.
  a_disjoint_swaps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORT) |-> ((cell_swap & (cell_swap >> 1)) == '0))
    else $error("overlapping exchanges in the cell chain");

endmodule

@@ rtl/mkrs_cell.sv @@
module mkrs_cell
  import mkrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       odd_pos,
  input  row_t       lo_row,
  input  logic       lo_valid,
  input  logic       lo_swap,
  input  row_t       up_row,
  input  logic       up_valid,
  output row_t       row,
  output logic       valid,
  output logic       swap
);

  logic lower_active;

  // In a sort phase this cell is the lower member of a pair when its position
  // parity matches the phase; otherwise it is the upper member.
  always_comb begin
    lower_active = (ctrl.op == OP_SORT) && (odd_pos == ctrl.phase);
    swap = lower_active && valid && up_valid &&
           row_after(up_row, row, ctrl.nkeys, ctrl.desc_mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.op == OP_SHIFT) begin
      valid <= lo_valid;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_SHIFT: begin
        row <= lo_row;
      end
      OP_SORT: begin
        if (swap) begin
          row <= up_row;
        end else if (!lower_active && lo_swap) begin
          row <= lo_row;
        end
      end
      default: begin
        row <= row;
      end
    endcase
  end

endmodule
